// ===== rtl/qrl_pkg.sv =====
// shared types and constants for the quota reservation ledger
`default_nettype none
package qrl_pkg;

  localparam logic [2:0] OP_RESERVE = 3'd0;
  localparam logic [2:0] OP_COMMIT  = 3'd1;
  localparam logic [2:0] OP_CANCEL  = 3'd2;
  localparam logic [2:0] OP_RELEASE = 3'd3;
  localparam logic [2:0] OP_TOTAL   = 3'd4;

  localparam logic [2:0] RC_OK       = 3'd0;
  localparam logic [2:0] RC_INVALID  = 3'd1;
  localparam logic [2:0] RC_CORRUPT  = 3'd2;
  localparam logic [2:0] RC_OVERFLOW = 3'd3;
  localparam logic [2:0] RC_BUSY     = 3'd4;
  localparam logic [2:0] RC_EXCEEDED = 3'd5;

  localparam logic [1:0] ST_FREE      = 2'd0;
  localparam logic [1:0] ST_RESERVED  = 2'd1;
  localparam logic [1:0] ST_COMMITTED = 2'd2;

  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] request_bytes;
    logic        enforce_limit;
    logic [3:0]  handle_slot;
    logic [63:0] handle_generation;
    logic        alloc_fail;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  granted_slot;
    logic [63:0] granted_generation;
    logic        warned;
    logic [63:0] charged_total;
    logic [63:0] limit_event_count;
    logic [63:0] denial_count;
    logic [63:0] failure_count;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture input item, clear scan state
    logic scan;     // examine one slot at the scan index
    logic decide;   // evaluate checks on the scan result
    logic commit;   // apply the update and form the result
  } qrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
  } qrl_sts_t;

endpackage
`default_nettype wire

// ===== rtl/qrl_ctrl.sv =====
// sequencer for load, slot scan, check and update of one item
`default_nettype none
module qrl_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output qrl_pkg::qrl_cmd_t    cmd,
  input  wire qrl_pkg::qrl_sts_t sts
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DECIDE = 5'b00100,
    S_UPDATE = 5'b01000,
    S_OUT    = 5'b10000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    unique case (state)
      S_IDLE: begin
        // no transfer is taken while reset is held
        in_stall = rst;
        if (in_valid && !rst) begin
          cmd.load = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.commit = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule
`default_nettype wire

// ===== rtl/qrl_datapath.sv =====
// slot table, running totals, event counters and the per-item checks
`default_nettype none
module qrl_datapath #(
  parameter int SLOTS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [63:0]       cfg_data,
  input  wire qrl_pkg::in_item_t in_item,
  input  wire qrl_pkg::qrl_cmd_t cmd,
  output qrl_pkg::qrl_sts_t      sts,
  output qrl_pkg::out_item_t     out_item
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [63:0] ONES = {64{1'b1}};

  logic [63:0] quota_limit;
  logic [1:0]  slot_state [SLOTS];
  logic [63:0] slot_bytes [SLOTS];
  logic [63:0] slot_generation [SLOTS];
  logic [63:0] used_total, reserved_total;
  logic [63:0] limit_hits, denials, failures;

  qrl_pkg::in_item_t item;
  logic [CW-1:0] idx;
  logic [IW-1:0] sidx;
  logic [63:0] sum_u, sum_r;
  logic        bad;
  logic        found;
  logic [IW-1:0] pick;

  // decide stage results
  logic [2:0]  rc;
  logic        warn_d;
  logic        hit_limit, deny;
  logic [63:0] charged;
  logic [IW-1:0] tslot;

  assign sidx = idx[IW-1:0];
  assign sts.scan_last = (idx == CW'(SLOTS - 1));

  // one slot per cycle
  logic [1:0]  c_st;
  logic [63:0] c_b, c_g;
  logic [64:0] add_u, add_r;
  assign c_st  = slot_state[sidx];
  assign c_b   = slot_bytes[sidx];
  assign c_g   = slot_generation[sidx];
  assign add_u = {1'b0, sum_u} + {1'b0, c_b};
  assign add_r = {1'b0, sum_r} + {1'b0, c_b};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item  <= in_item;
      idx   <= '0;
      sum_u <= '0;
      sum_r <= '0;
      bad   <= 1'b0;
      found <= 1'b0;
      pick  <= '0;
    end else if (cmd.scan) begin
      idx <= idx + CW'(1);
      unique case (c_st)
        qrl_pkg::ST_FREE: begin
          if (c_b != '0) bad <= 1'b1;
          if (!found && c_g != ONES) begin
            found <= 1'b1;
            pick  <= sidx;
          end
        end
        qrl_pkg::ST_RESERVED: begin
          if (c_b == '0 || c_g == '0 || add_r[64]) bad <= 1'b1;
          sum_r <= add_r[63:0];
        end
        qrl_pkg::ST_COMMITTED: begin
          if (c_b == '0 || c_g == '0 || add_u[64]) bad <= 1'b1;
          sum_u <= add_u[63:0];
        end
        default: bad <= 1'b1;
      endcase
    end
  end

  // decide: two wide adds and compares
  logic [64:0] tot65, req65;
  logic        ledger_ok;
  logic        h_ok_res, h_ok_com, h_range;
  logic [IW-1:0] hs;
  logic [1:0]  h_st;
  logic [63:0] h_b, h_g;
  assign tot65 = {1'b0, sum_u} + {1'b0, sum_r};
  assign ledger_ok = !bad && sum_u == used_total && sum_r == reserved_total && !tot65[64];
  assign req65 = {1'b0, tot65[63:0]} + {1'b0, item.request_bytes};
  assign h_range = ({{(64-4){1'b0}}, item.handle_slot} < 64'(SLOTS));
  assign hs   = h_range ? IW'(item.handle_slot) : '0;
  assign h_st = slot_state[hs];
  assign h_b  = slot_bytes[hs];
  assign h_g  = slot_generation[hs];
  assign h_ok_res = item.handle_generation != '0 && h_range &&
                    h_g == item.handle_generation && h_st == qrl_pkg::ST_RESERVED &&
                    h_b != '0;
  assign h_ok_com = item.handle_generation != '0 && h_range &&
                    h_g == item.handle_generation && h_st == qrl_pkg::ST_COMMITTED &&
                    h_b != '0;

  logic [2:0] rc_c;
  logic       over;
  assign over = quota_limit != '0 && req65 > {1'b0, quota_limit};

  always_comb begin
    rc_c = qrl_pkg::RC_OK;
    unique case (item.op)
      qrl_pkg::OP_RESERVE: begin
        priority if (item.request_bytes == '0) rc_c = qrl_pkg::RC_INVALID;
        else if (!ledger_ok) rc_c = qrl_pkg::RC_CORRUPT;
        else if (req65[64]) rc_c = qrl_pkg::RC_OVERFLOW;
        else if (!found) rc_c = qrl_pkg::RC_BUSY;
        else if (over && item.enforce_limit) rc_c = qrl_pkg::RC_EXCEEDED;
        else rc_c = qrl_pkg::RC_OK;
      end
      qrl_pkg::OP_COMMIT, qrl_pkg::OP_CANCEL: begin
        if (!h_ok_res || !ledger_ok || reserved_total < h_b) rc_c = qrl_pkg::RC_CORRUPT;
      end
      qrl_pkg::OP_RELEASE: begin
        if (!h_ok_com || !ledger_ok || used_total < h_b) rc_c = qrl_pkg::RC_CORRUPT;
      end
      qrl_pkg::OP_TOTAL: begin
        if (!ledger_ok) rc_c = qrl_pkg::RC_CORRUPT;
      end
      default: rc_c = qrl_pkg::RC_INVALID;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      rc        <= rc_c;
      charged   <= (item.op == qrl_pkg::OP_RESERVE) ? req65[63:0] : tot65[63:0];
      hit_limit <= item.op == qrl_pkg::OP_RESERVE && item.request_bytes != '0 &&
                   ledger_ok && !req65[64] && found && over;
      deny      <= item.enforce_limit;
      warn_d    <= over;
      tslot     <= (item.op == qrl_pkg::OP_RESERVE) ? pick : hs;
    end
  end

  // update
  logic [63:0] t_b, t_g, gen_inc;
  logic        ok;
  assign t_b = slot_bytes[tslot];
  assign t_g = slot_generation[tslot];
  assign gen_inc = t_g + 64'd1;
  assign ok = rc == qrl_pkg::RC_OK;

  always_ff @(posedge clk) begin
    if (rst) begin
      quota_limit    <= '0;
      used_total     <= '0;
      reserved_total <= '0;
      limit_hits     <= '0;
      denials        <= '0;
      failures       <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_state[i]      <= qrl_pkg::ST_FREE;
        slot_bytes[i]      <= '0;
        slot_generation[i] <= '0;
      end
    end else begin
      if (cfg_we) quota_limit <= cfg_data;
      if (cmd.commit) begin
        if (hit_limit && limit_hits != ONES) limit_hits <= limit_hits + 64'd1;
        if (hit_limit && deny && denials != ONES) denials <= denials + 64'd1;
        if (ok) begin
          unique case (item.op)
            qrl_pkg::OP_RESERVE: begin
              reserved_total         <= reserved_total + item.request_bytes;
              slot_bytes[tslot]      <= item.request_bytes;
              slot_generation[tslot] <= gen_inc;
              slot_state[tslot]      <= qrl_pkg::ST_RESERVED;
            end
            qrl_pkg::OP_COMMIT: begin
              reserved_total    <= reserved_total - t_b;
              used_total        <= used_total + t_b;
              slot_state[tslot] <= qrl_pkg::ST_COMMITTED;
            end
            qrl_pkg::OP_CANCEL: begin
              reserved_total    <= reserved_total - t_b;
              slot_bytes[tslot] <= '0;
              slot_state[tslot] <= qrl_pkg::ST_FREE;
              if (item.alloc_fail && failures != ONES) failures <= failures + 64'd1;
            end
            qrl_pkg::OP_RELEASE: begin
              used_total        <= used_total - t_b;
              slot_bytes[tslot] <= '0;
              slot_state[tslot] <= qrl_pkg::ST_FREE;
            end
            default: ;
          endcase
        end
      end
    end
  end

  // result register, counters are read live since nothing moves until next item
  logic [2:0]  r_status;
  logic [3:0]  r_slot;
  logic [63:0] r_gen, r_tot;
  logic        r_warn;
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      r_status <= rc;
      r_slot   <= '0;
      r_gen    <= '0;
      r_warn   <= 1'b0;
      r_tot    <= '0;
      if (ok && item.op == qrl_pkg::OP_RESERVE) begin
        r_slot <= 4'(tslot);
        r_gen  <= gen_inc;
        r_warn <= warn_d;
        r_tot  <= charged;
      end else if (ok && item.op == qrl_pkg::OP_TOTAL) begin
        r_tot <= charged;
      end
    end
  end

  assign out_item.status             = r_status;
  assign out_item.granted_slot       = r_slot;
  assign out_item.granted_generation = r_gen;
  assign out_item.warned             = r_warn;
  assign out_item.charged_total      = r_tot;
  assign out_item.limit_event_count  = limit_hits;
  assign out_item.denial_count       = denials;
  assign out_item.failure_count      = failures;

endmodule
`default_nettype wire

// ===== rtl/quota_reservation_ledger_top.sv =====
// top level of the quota reservation ledger
`default_nettype none
// byte-quota ledger over a table of RESERVATION_SLOTS slots. each transfer
// on the input channel is one op (reserve, commit, cancel, release, total)
// and yields exactly one result transfer. an op walks the slot table one
// slot a cycle to re-sum the totals, check invariants and find the first
// free slot with a usable generation, then does a check step and an update
// step before the output handshake. one op is in flight at a time;
// quota_limit must be written by the user only while idle; not enforced.
module quota_reservation_ledger_top #(
  parameter int RESERVATION_SLOTS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [63:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire qrl_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output qrl_pkg::out_item_t      out_data
);

  // command and status between sequencer and datapath
  qrl_pkg::qrl_cmd_t cmd;
  qrl_pkg::qrl_sts_t sts;

  qrl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  qrl_datapath #(.SLOTS(RESERVATION_SLOTS)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_item  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_item (out_data)
  );

endmodule
`default_nettype wire
